>>> sv/assert_macros.svh
// Assertion macros used by the checker of this project.
// Each macro samples on posedge clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: assertion failed");

// Condition must never be true at a clock edge out of reset.
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("%m: forbidden condition seen");

`endif

>>> sv/mxbh_pkg.sv
// ----------------------------------------------------------------------------
// mxbh_pkg
// Types, constants and constant-multiply helpers of the multiply/xor byte hash.
// ----------------------------------------------------------------------------
`default_nettype none

package mxbh_pkg;

  typedef enum logic [1:0] {
    MODE_32_MUL_XOR = 2'd0,
    MODE_32_XOR_MUL = 2'd1,
    MODE_64_MUL_XOR = 2'd2,
    MODE_64_XOR_MUL = 2'd3
  } hash_mode_t;

  localparam hash_mode_t MODE_RESET = MODE_64_XOR_MUL;

  localparam logic [63:0] OFFSET_32 = 64'd5381;
  localparam logic [63:0] OFFSET_64 = 64'd14695981039346656037;

  // One input transaction.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       first_byte;
    logic       last_byte;
  } item_t;

  function automatic logic mode_is_wide(hash_mode_t m);
    return (m == MODE_64_MUL_XOR) || (m == MODE_64_XOR_MUL);
  endfunction

  function automatic logic mode_xor_first(hash_mode_t m);
    return (m == MODE_32_XOR_MUL) || (m == MODE_64_XOR_MUL);
  endfunction

  function automatic logic [63:0] mode_offset(hash_mode_t m);
    return mode_is_wide(m) ? OFFSET_64 : OFFSET_32;
  endfunction

  // h * 1099511628211 mod 2^64; prime = 2^40 + 0x1B3
  function automatic logic [63:0] mul_prime64(logic [63:0] h);
    return (h << 40) + (h << 8) + (h << 7) + (h << 5) + (h << 4) + (h << 1) + h;
  endfunction

  // h * 33 mod 2^32
  function automatic logic [31:0] mul33(logic [31:0] h);
    return (h << 5) + h;
  endfunction

endpackage

`default_nettype wire

>>> sv/mxbh_if.sv
// ----------------------------------------------------------------------------
// mxbh_if
// Valid/ready channel interfaces: byte input, hash result, mode configuration.
// ----------------------------------------------------------------------------
`default_nettype none

interface mxbh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       first_byte;
  logic       last_byte;

  modport source (output valid, data_byte, byte_present, first_byte, last_byte,
                  input ready);
  modport sink   (input valid, data_byte, byte_present, first_byte, last_byte,
                  output ready);
endinterface

interface mxbh_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash_value;

  modport source (output valid, hash_value, input ready);
  modport sink   (input valid, hash_value, output ready);
endinterface

interface mxbh_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] hash_mode;

  modport source (output valid, hash_mode, input ready);
  modport sink   (input valid, hash_mode, output ready);
endinterface

`default_nettype wire

>>> sv/mxbh_mix.sv
// ----------------------------------------------------------------------------
// mxbh_mix
// One hash step: offset reload, byte mix in the selected order, result mask.
// ----------------------------------------------------------------------------
`default_nettype none

module mxbh_mix (
  input  wire logic [63:0]         hash_i,
  input  wire mxbh_pkg::item_t     item_i,
  input  wire mxbh_pkg::hash_mode_t mode_i,
  output logic [63:0]              hash_o,
  output logic [63:0]              result_o
);

  logic        wide;
  logic        xor_first;
  logic [63:0] start;
  logic [63:0] start_m;
  logic [63:0] byte_ext;
  logic [63:0] mul_src;
  logic [63:0] prod;
  logic [63:0] mixed;

  always_comb begin
    wide      = mxbh_pkg::mode_is_wide(mode_i);
    xor_first = mxbh_pkg::mode_xor_first(mode_i);
    start     = item_i.first_byte ? mxbh_pkg::mode_offset(mode_i) : hash_i;
    start_m   = wide ? start : {32'd0, start[31:0]};
    byte_ext  = {56'd0, item_i.data_byte};
    mul_src   = xor_first ? (start_m ^ byte_ext) : start_m;
    prod      = wide ? mxbh_pkg::mul_prime64(mul_src)
                     : {32'd0, mxbh_pkg::mul33(mul_src[31:0])};
    mixed     = xor_first ? prod : (prod ^ byte_ext);
    // no byte: state keeps its full 64 bits, only the result is masked
    hash_o    = item_i.byte_present ? mixed : start;
    result_o  = wide ? hash_o : {32'd0, hash_o[31:0]};
  end

endmodule

`default_nettype wire

>>> sv/multiplicative_xor_byte_hash.sv
// ----------------------------------------------------------------------------
// multiplicative_xor_byte_hash
// Streaming byte hash, 64-bit FNV or 32-bit x33/5381, mul-xor or xor-mul order.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  in_ch     in   valid/ready        data_byte, byte_present, first_byte, last_byte
//  out_ch    out  valid/ready        hash_value (64b, upper half zero in 32b modes)
//  cfg_ch    in   valid/ready (rdy=1) hash_mode (2b)
//
//  One byte per cycle sustained unless a last item waits on an unread result.
//  An accepted transaction is registered in the input stage, then folded into
//  the running hash; a last item also loads the result and raises out_ch.valid.
//  The hash step (a 64- or 32-bit constant multiply as shifted adds) sits
//  between the input stage and the hash/result registers.
//  in_ch stalls only while a last item waits on a full, unread result register.
//  Reset: mode 3, running hash = 64-bit offset basis, both stages empty.
// ----------------------------------------------------------------------------
`default_nettype none

module multiplicative_xor_byte_hash (
  input wire logic     clk,
  input wire logic     rst_n,
  mxbh_in_if.sink      in_ch,
  mxbh_out_if.source   out_ch,
  mxbh_cfg_if.sink     cfg_ch
);

  mxbh_pkg::hash_mode_t mode_r;
  logic                 s_valid_r;
  mxbh_pkg::item_t      s_item_r;
  logic [63:0]          hash_r;
  logic [63:0]          hash_nxt;
  logic [63:0]          result_nxt;
  logic                 out_valid_r;
  logic [63:0]          out_hash_r;

  logic out_free;
  logic s_go;
  logic in_ready;

  mxbh_mix u_mix (
    .hash_i   (hash_r),
    .item_i   (s_item_r),
    .mode_i   (mode_r),
    .hash_o   (hash_nxt),
    .result_o (result_nxt)
  );

  always_comb begin
    out_free = !out_valid_r || out_ch.ready;
    s_go     = s_valid_r && (!s_item_r.last_byte || out_free);
    in_ready = !s_valid_r || s_go;
  end

  assign in_ch.ready       = in_ready;
  assign cfg_ch.ready      = 1'b1;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.hash_value = out_hash_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= mxbh_pkg::MODE_RESET;
      s_valid_r   <= 1'b0;
      hash_r      <= mxbh_pkg::OFFSET_64;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        mode_r <= mxbh_pkg::hash_mode_t'(cfg_ch.hash_mode);
      end
      if (in_ready) begin
        s_valid_r <= in_ch.valid;
      end
      if (s_go) begin
        hash_r <= hash_nxt;
      end
      if (s_go && s_item_r.last_byte) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      s_item_r.data_byte    <= in_ch.data_byte;
      s_item_r.byte_present <= in_ch.byte_present;
      s_item_r.first_byte   <= in_ch.first_byte;
      s_item_r.last_byte    <= in_ch.last_byte;
    end
    if (s_go && s_item_r.last_byte) begin
      out_hash_r <= result_nxt;
    end
  end

endmodule

`default_nettype wire

>>> sv/mxbh_checker.sv
// ----------------------------------------------------------------------------
// mxbh_checker
// Port-level checks of the byte hash, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mxbh_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [63:0] out_hash,
  input wire logic        cfg_valid,
  input wire logic        cfg_ready,
  input wire logic [1:0]  cfg_mode
);

  mxbh_pkg::hash_mode_t mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= mxbh_pkg::MODE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      mode_r <= mxbh_pkg::hash_mode_t'(cfg_mode);
    end
  end

  // a result waiting on the sink holds its value
  `ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_hash))
  // 32-bit modes give zero-extended results
  `ASSERT_NEVER(a_narrow_upper, out_valid && !mxbh_pkg::mode_is_wide(mode_r)
                && (out_hash[63:32] != 32'd0))
  // input only stalls behind a pending result
  `ASSERT_CLK(a_no_idle_stall, !out_valid |-> in_ready)
  // a valid input is never stalled while no result is pending
  `ASSERT_NEVER(a_in_valid_x, in_valid && !in_ready && !out_valid)

endmodule

bind multiplicative_xor_byte_hash mxbh_checker u_mxbh_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_hash  (out_ch.hash_value),
  .cfg_valid (cfg_ch.valid),
  .cfg_ready (cfg_ch.ready),
  .cfg_mode  (cfg_ch.hash_mode)
);

`default_nettype wire
